// ===== hdl/assert_macros.svh =====
// assertion macros used by the position sensor emulator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define PSE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// plain condition that must hold on every rising clock edge outside reset
`define PSE_ASSERT_ALWAYS(label, cond, msg) \
   `PSE_ASSERT(label, (1'b1 |-> (cond)), msg)

`endif

// ===== hdl/pse_pkg.sv =====
// types, constants and follower step function for the position sensor emulator
`timescale 1ns / 1ps
`default_nettype none

package pse_pkg;

   localparam int SW_W  = 13;
   localparam int CNT_W = 14;
   localparam int CSR_W = 16;

   localparam logic [SW_W-1:0]  SW_MAX  = 13'd8191;
   localparam logic [CNT_W-1:0] CNT_MAX = 14'd16383;

   // register indexes on the csr port
   localparam logic CSR_SWITCHOVER_DELAY = 1'b0;
   localparam logic CSR_EMULATION_DELAY  = 1'b1;

   typedef struct packed {
      logic emulate_enable;
      logic up_sensor_active;
      logic down_sensor_active;
      logic grip_sensor_active;
      logic valve_drive;
      logic gripper_drive;
   } req_type;

   typedef struct packed {
      logic at_up;
      logic at_down;
      logic grip_closed;
      logic emulating;
   } rsp_type;

   typedef struct packed {
      logic             seen;
      logic             known;
      logic             pend;
      logic [CNT_W-1:0] cnt;
   } follower_type;

   typedef struct packed {
      follower_type state;
      logic         update;
   } follow_out_type;

   // one tick of a delayed follower
   function automatic follow_out_type follow_step(follower_type cur, logic drive,
                                                  logic [CNT_W-1:0] dly);
      follow_out_type res;
      logic           changed;
      logic [CNT_W-1:0] cnt_inc;
      res     = '0;
      changed = cur.known && (drive != cur.seen);
      res.state.known = 1'b1;
      res.state.seen  = (!cur.known || changed) ? drive : cur.seen;
      res.state.pend  = changed ? 1'b1 : cur.pend;
      res.state.cnt   = changed ? '0 : cur.cnt;
      res.update      = !cur.known;
      if (res.state.pend) begin
         cnt_inc = (res.state.cnt < CNT_MAX) ? res.state.cnt + 1'b1 : res.state.cnt;
         res.state.cnt = cnt_inc;
         if (cnt_inc >= dly) begin
            res.state.pend = 1'b0;
            res.update     = 1'b1;
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/position_sensor_emulator.sv =====
// position sensor emulator top level
`timescale 1ns / 1ps
`default_nettype none

// Position sensor emulator. One request is one sensor tick of TICK_MS milliseconds and
// gives exactly one response. With emulate_enable low the reported up, down and grip
// positions copy the real sensors; with it high, up/down follow the valve drive and grip
// follows the gripper drive, each drive change showing after the emulation delay
// (round(ms / TICK_MS) ticks, at least one). Raising the enable restarts both followers,
// which then report the drives at once on the first emulated tick. Dropping the enable
// keeps emulation on for floor(ms / TICK_MS) - 1 more ticks (at least one tick counted).
// Throughput is one request per clock unless the response stalls. A request passes the
// request register, then the response register, all tick state updated as it moves into
// the response register. A waiting response does not block the next request: the request
// register holds it. The two delay registers are turned into tick counts when written,
// through a reciprocal multiply by the tick length, so they must be written while no
// request is in flight. Reset state: both delays read as zero ms, followers unknown.
module position_sensor_emulator #(
   parameter int TICK_MS = 10
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire  pse_pkg::req_type       req_data,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output pse_pkg::rsp_type             rsp_data,
   input  wire                          csr_write_en,
   input  wire                          csr_index,
   input  wire  [pse_pkg::CSR_W-1:0]    csr_wdata
);
   import pse_pkg::*;

   `include "assert_macros.svh"

   // reciprocal constants: q = (x * m) >> s is exact for x below 2^DIV_N
   localparam int    DIV_N   = 18;
   localparam int    M_W     = DIV_N + 2;
   localparam int    SW_DIV  = TICK_MS;
   localparam int    DLY_DIV = 2 * TICK_MS;
   localparam int    SW_S    = DIV_N + $clog2(SW_DIV);
   localparam int    DLY_S   = DIV_N + $clog2(DLY_DIV);
   localparam longint SW_M   = ((longint'(1) << SW_S) + SW_DIV - 1) / SW_DIV;
   localparam longint DLY_M  = ((longint'(1) << DLY_S) + DLY_DIV - 1) / DLY_DIV;
   localparam logic [M_W-1:0] SW_MULT  = SW_M[M_W-1:0];
   localparam logic [M_W-1:0] DLY_MULT = DLY_M[M_W-1:0];

   // config: derived tick counts
   logic [SW_W-1:0]        sw_ticks_ff, sw_ticks_in;
   logic [CNT_W-1:0]       dly_ticks_ff, dly_ticks_in;
   logic [DIV_N-1:0]       sw_x, dly_x;
   logic [DIV_N+M_W-1:0]   sw_prod, dly_prod;
   logic [DIV_N-1:0]       sw_q, dly_q;

   // pipeline registers
   logic    req_valid_ff, req_valid_in;
   req_type req_data_ff, req_data_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    req_accept, move;

   // tick state
   logic             prior_ff, prior_in;
   logic             prior_known_ff, prior_known_in;
   logic [SW_W-1:0]  sw_count_ff, sw_count_in;
   follower_type     valve_ff, valve_in;
   follower_type     grip_ff, grip_in;
   logic [2:0]       rep_ff, rep_in;

   // step temporaries
   logic            prior_eff, rising;
   logic [SW_W-1:0] sw_load;
   follower_type    valve_cur, grip_cur;
   follow_out_type  valve_res, grip_res;
   logic            use_emu;

   // ---------------- configuration ----------------
   always_comb begin
      sw_x     = {{(DIV_N-CSR_W){1'b0}}, csr_wdata};
      dly_x    = {{(DIV_N-CSR_W-1){1'b0}}, csr_wdata, 1'b0} + DIV_N'(TICK_MS);
      sw_prod  = {{M_W{1'b0}}, sw_x} * {{DIV_N{1'b0}}, SW_MULT};
      dly_prod = {{M_W{1'b0}}, dly_x} * {{DIV_N{1'b0}}, DLY_MULT};
      sw_q     = DIV_N'(sw_prod >> SW_S);
      dly_q    = DIV_N'(dly_prod >> DLY_S);

      // clamp to at least one tick and to the counter range
      sw_ticks_in = sw_ticks_ff;
      dly_ticks_in = dly_ticks_ff;
      if (csr_write_en && csr_index == CSR_SWITCHOVER_DELAY) begin
         if (sw_q == '0)
            sw_ticks_in = SW_W'(1);
         else if (sw_q > DIV_N'(SW_MAX))
            sw_ticks_in = SW_MAX;
         else
            sw_ticks_in = sw_q[SW_W-1:0];
      end
      if (csr_write_en && csr_index == CSR_EMULATION_DELAY) begin
         if (dly_q == '0)
            dly_ticks_in = CNT_W'(1);
         else if (dly_q > DIV_N'(CNT_MAX))
            dly_ticks_in = CNT_MAX;
         else
            dly_ticks_in = dly_q[CNT_W-1:0];
      end
   end

   // ---------------- handshake ----------------
   // request moves into the response register when that register is free or draining
   assign move       = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = req_valid_ff && !move;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      req_valid_in = req_accept || (req_valid_ff && !move);
      req_data_in  = req_accept ? req_data : req_data_ff;
      rsp_valid_in = move || (rsp_valid_ff && rsp_stall);
   end

   // ---------------- tick step ----------------
   always_comb begin
      // unknown prior enable takes this tick's value, so no edge on the first tick
      prior_eff = prior_known_ff ? prior_ff : req_data_ff.emulate_enable;
      rising    = !prior_eff && req_data_ff.emulate_enable;
      sw_load   = (prior_eff && !req_data_ff.emulate_enable) ? sw_ticks_ff : sw_count_ff;

      // entering emulation restarts both followers
      valve_cur = valve_ff;
      grip_cur  = grip_ff;
      if (rising) begin
         valve_cur.known = 1'b0;
         valve_cur.pend  = 1'b0;
         grip_cur.known  = 1'b0;
         grip_cur.pend   = 1'b0;
      end

      sw_count_in = (sw_load != '0) ? sw_load - 1'b1 : sw_load;
      use_emu     = req_data_ff.emulate_enable || (sw_count_in != '0);

      valve_res = follow_step(valve_cur, req_data_ff.valve_drive, dly_ticks_ff);
      grip_res  = follow_step(grip_cur, req_data_ff.gripper_drive, dly_ticks_ff);

      prior_in       = req_data_ff.emulate_enable;
      prior_known_in = 1'b1;
      valve_in       = valve_cur;
      grip_in        = grip_cur;
      rep_in         = rep_ff;

      if (!use_emu) begin
         // real mode: copy sensors, followers frozen
         rep_in = {req_data_ff.grip_sensor_active, req_data_ff.down_sensor_active,
                   req_data_ff.up_sensor_active};
      end else begin
         valve_in = valve_res.state;
         grip_in  = grip_res.state;
         if (valve_res.update)
            rep_in[1:0] = {req_data_ff.valve_drive, ~req_data_ff.valve_drive};
         if (grip_res.update)
            rep_in[2] = req_data_ff.gripper_drive;
      end

      rsp_data_in.at_up       = rep_in[0];
      rsp_data_in.at_down     = rep_in[1];
      rsp_data_in.grip_closed = rep_in[2];
      rsp_data_in.emulating   = use_emu;
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ticks_ff    <= SW_W'(1);
         dly_ticks_ff   <= CNT_W'(1);
         req_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         prior_ff       <= 1'b0;
         prior_known_ff <= 1'b0;
         sw_count_ff    <= '0;
         valve_ff       <= '0;
         grip_ff        <= '0;
         rep_ff         <= '0;
      end else begin
         sw_ticks_ff  <= sw_ticks_in;
         dly_ticks_ff <= dly_ticks_in;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (move) begin
            prior_ff       <= prior_in;
            prior_known_ff <= prior_known_in;
            sw_count_ff    <= sw_count_in;
            valve_ff       <= valve_in;
            grip_ff        <= grip_in;
            rep_ff         <= rep_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_data_ff <= req_data_in;
      if (move)
         rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- assertions ----------------
   `PSE_ASSERT(a_enable_emulates, move && req_data_ff.emulate_enable |=> rsp_data_ff.emulating, "enabled request did not report emulation")
   `PSE_ASSERT_ALWAYS(a_valve_pend_known, !valve_ff.pend || valve_ff.known, "valve follower pending while unknown")
   `PSE_ASSERT_ALWAYS(a_ticks_nonzero, sw_ticks_ff != '0 && dly_ticks_ff != '0, "derived tick count is zero")
   `PSE_ASSERT(a_held_request_kept, req_valid_ff && !move |=> req_valid_ff && $stable(req_data_ff), "held request lost")

endmodule

`default_nettype wire
